FILE: design/wildcard_pattern_matcher_top_defines.svh
// ----------------------------------------------------------------------------
// Wildcard pattern matcher: assertion macros
// Shared property macros for the checker of the matcher's ports.
// ----------------------------------------------------------------------------
`ifndef WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WPM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define WPM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/wpm_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Opcodes, wildcard characters and the control bundle sent along the cells.
// ----------------------------------------------------------------------------
package wpm_pkg;

  typedef logic [7:0] char_t;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_START  = 2'd2,
    OP_TEXT   = 2'd3
  } opcode_t;

  localparam char_t STAR_CHAR  = 8'h2A;
  localparam char_t QMARK_CHAR = 8'h3F;

  // One-cycle strobes for an accepted item, broadcast to every cell
  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic text;
  } wpm_ctl_t;

endpackage

FILE: design/wpm_cell.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds one pattern byte, its match-row bit and its leading-star bit, and
// forms the generate/propagate pair for the star chain of a text byte.
// ----------------------------------------------------------------------------
module wpm_cell (
  input  logic             clk,
  input  logic             rst,
  input  wpm_pkg::wpm_ctl_t ctl,
  input  wpm_pkg::char_t   char_value,
  input  logic             active,
  input  logic             pick,
  input  logic             left_row,
  input  logic             left_lead,
  input  logic             chain_bit,
  output logic             gen,
  output logic             prop,
  output logic             row,
  output logic             lead,
  output logic             row_upd
);
  import wpm_pkg::*;

  char_t pat;
  logic  is_eq;
  logic  is_star;
  logic  lead_next;
  logic  update;

  // Store the pattern byte when this slot is the next free one
  always_ff @(posedge clk) begin
    if (ctl.append && pick) begin
      pat <= char_value;
    end
  end

  // Classify the stored byte against the text byte
  assign is_eq   = (pat == char_value) || (pat == QMARK_CHAR);
  assign is_star = (pat == STAR_CHAR);

  // Literal match takes the diagonal; a star may also extend from above or left
  always_comb begin
    gen  = 1'b0;
    prop = 1'b0;
    if (active) begin
      if (is_eq) begin
        gen = left_row;
      end else if (is_star) begin
        gen  = left_row | row;
        prop = 1'b1;
      end
    end
  end

  // Leading-star bit: set only while the whole prefix is stars
  always_comb begin
    lead_next = lead;
    if (ctl.clear) begin
      lead_next = 1'b0;
    end else if (ctl.append && pick) begin
      lead_next = left_lead && (char_value == STAR_CHAR);
    end
  end

  assign row_upd = ctl.text ? chain_bit : lead_next;
  assign update  = ctl.clear | ctl.append | ctl.start | ctl.text;

  // Advance the row bit and the leading-star bit
  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= 1'b0;
      lead <= 1'b0;
    end else if (update) begin
      row  <= row_upd;
      lead <= lead_next;
    end
  end

endmodule

FILE: design/wildcard_pattern_matcher_top.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Matches a streamed text against a stored pattern with '?' and '*'.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_stall, opcode, char_value) carries
//   commands: clear pattern, append pattern byte, start text, text byte.
//   Start and text-byte items each give one result on the result channel
//   (result_valid/result_stall, matched, overflow); clear and append give none.
//   For every item taken, a row of cells, one per pattern position,
//   updates the whole match row in the cycle the item is taken, and the
//   star runs resolve through one carry chain across the row. A result
//   appears in the output register in the cycle after its item is taken.
//   Throughput is one item per cycle unless a stalled result holds items.
//   While a result waits under result_stall, start and text-byte items are
//   stalled; clear and append items still pass.
//   Reset empties the pattern, clears the overflow flag and drops any
//   pending result. Appending to a full pattern drops the byte and sets the
//   sticky overflow flag, which only reset clears.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_top #(
  parameter int MAX_PATTERN = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          opcode,
  input  wpm_pkg::char_t      char_value,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                matched,
  output logic                overflow
);
  import wpm_pkg::*;

  localparam int W  = MAX_PATTERN + 1;
  localparam int CW = $clog2(MAX_PATTERN + 1);

  logic          take;
  logic          gives_result;
  wpm_ctl_t      ctl;
  logic [CW-1:0] count;
  logic          row0;
  logic          overflow_flag;
  logic          full;

  logic [W-1:0]  row_vec;
  logic [W-1:0]  lead_vec;
  logic [W-1:0]  gen_vec;
  logic [W-1:0]  prop_vec;
  logic [W-1:0]  upd_vec;
  logic [W-1:0]  chain_vec;
  logic [W-1:0]  end_vec;
  logic [W:0]    add_a;
  logic [W:0]    add_b;
  logic [W:0]    add_sum;
  logic [W:0]    carry_vec;
  logic          matched_next;

  // Decode the item and the handshake
  assign gives_result = (opcode == OP_START) || (opcode == OP_TEXT);
  assign item_stall   = result_valid && result_stall && gives_result;
  assign take         = item_valid && !item_stall;
  assign full         = (count == CW'(MAX_PATTERN));

  assign ctl.clear  = take && (opcode == OP_CLEAR);
  assign ctl.append = take && (opcode == OP_APPEND);
  assign ctl.start  = take && (opcode == OP_START);
  assign ctl.text   = take && (opcode == OP_TEXT);

  // Position zero matches only the empty text and is never a pattern byte
  assign row_vec[0]  = row0;
  assign lead_vec[0] = 1'b1;
  assign gen_vec[0]  = 1'b0;
  assign prop_vec[0] = 1'b0;
  assign upd_vec[0]  = !ctl.text;
  assign end_vec[0]  = (count == '0);

  // Row of cells, one per pattern position
  for (genvar j = 1; j < W; j++) begin : g_cell
    assign end_vec[j] = (count == CW'(j));

    wpm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .char_value (char_value),
      .active     (CW'(j) <= count),
      .pick       (count == CW'(j - 1)),
      .left_row   (row_vec[j-1]),
      .left_lead  (lead_vec[j-1]),
      .chain_bit  (chain_vec[j]),
      .gen        (gen_vec[j]),
      .prop       (prop_vec[j]),
      .row        (row_vec[j]),
      .lead       (lead_vec[j]),
      .row_upd    (upd_vec[j])
    );
  end

  // Resolve star runs as a carry chain: the carry out of each position is
  // its new row bit (generate, or propagate with the bit to its left)
  assign add_a     = {1'b0, gen_vec | prop_vec};
  assign add_b     = {1'b0, gen_vec};
  assign add_sum   = add_a + add_b;
  assign carry_vec = add_sum ^ add_a ^ add_b;
  assign chain_vec = carry_vec[W:1];

  // Pick the row bit at the pattern length
  assign matched_next = |(upd_vec & end_vec);

  // Hold pattern length, position zero and the sticky overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      row0          <= 1'b1;
      overflow_flag <= 1'b0;
    end else begin
      if (ctl.clear) begin
        count <= '0;
      end else if (ctl.append && !full) begin
        count <= count + CW'(1);
      end
      if (ctl.append && full) begin
        overflow_flag <= 1'b1;
      end
      if (ctl.clear || ctl.append || ctl.start || ctl.text) begin
        row0 <= upd_vec[0];
      end
    end
  end

  // Output register: load on a result-giving transfer, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.start || ctl.text) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start || ctl.text) begin
      matched  <= matched_next;
      overflow <= overflow_flag;
    end
  end

endmodule

FILE: design/wpm_checker.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher checker
// Port-level assertions on the matcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "wildcard_pattern_matcher_top_defines.svh"

module wpm_checker (
  input logic           clk,
  input logic           rst,
  input logic           item_valid,
  input logic           item_stall,
  input logic [1:0]     opcode,
  input wpm_pkg::char_t char_value,
  input logic           result_valid,
  input logic           result_stall,
  input logic           matched,
  input logic           overflow
);
  import wpm_pkg::*;

  logic        gives_result;
  logic        item_wait;
  logic        result_wait;
  logic        result_item;
  logic        result_ask;
  logic        flag_shown;
  logic [10:0] item_word;
  logic [2:0]  result_word;

  // Decode the handshakes and gather each channel's visible state
  assign gives_result = (opcode == OP_START) || (opcode == OP_TEXT);
  assign item_wait    = item_valid && item_stall;
  assign result_wait  = result_valid && result_stall;
  assign result_item  = item_valid && !item_stall && gives_result;
  assign result_ask   = item_valid && gives_result;
  assign flag_shown   = result_valid && overflow;
  assign item_word    = {item_valid, opcode, char_value};
  assign result_word  = {result_valid, matched, overflow};

  // A stalled item keeps its valid and payload
  `WPM_ASSERT_NXT(a_item_hold, clk, rst, item_wait, $stable(item_word), "stalled item changed")

  // A stalled result keeps its valid and payload
  `WPM_ASSERT_NXT(a_result_hold, clk, rst, result_wait, $stable(result_word), "stalled result changed")

  // Overflow never falls once reported
  `WPM_ASSERT_NXT(a_overflow_sticky, clk, rst, flag_shown, !result_valid || overflow, "overflow fell")

  // A start or text transfer yields a result next cycle
  `WPM_ASSERT_NXT(a_result_follows, clk, rst, result_item, result_valid, "result missing")

  // A waiting result blocks result-giving items
  `WPM_ASSERT_IMP(a_block_on_wait, clk, rst, result_ask && result_wait, item_stall, "result overrun")

endmodule

bind wildcard_pattern_matcher_top wpm_checker u_wpm_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .opcode       (opcode),
  .char_value   (char_value),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .matched      (matched),
  .overflow     (overflow)
);

FILE: verif/wildcard_match_checker.sv
// ----------------------------------------------------------------------------
// Wildcard match checker
// Watches the item and result channels of the wildcard pattern matcher,
// keeps its own copy of the pattern and the match row, predicts the result
// of every start and text-byte transfer and compares each result transfer
// with the oldest prediction.
// ----------------------------------------------------------------------------
module wildcard_match_checker #(
  parameter int MAX_PATTERN = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic           item_stall,
  input  logic [1:0]     opcode,
  input  wpm_pkg::char_t char_value,
  input  logic           result_valid,
  input  logic           result_stall,
  input  logic           matched,
  input  logic           overflow,
  output int             mismatch_count,
  output int             pending_count,
  output int             results_checked,
  output int             matches_seen,
  output logic           overflow_seen
);
  import wpm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_result_t;

  char_t                pattern_bytes [MAX_PATTERN];
  int                   pattern_len;
  logic [MAX_PATTERN:0] match_bits;
  logic                 overflow_sticky;
  match_result_t        expected_q [$];

  // Print one line per mismatch (up to a cap) and count it
  task automatic report_mismatch(string what, int got_val, int want_val);
    if (mismatch_count < 100) begin
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got_val, want_val, $time);
    end
    mismatch_count++;
  endtask

  // Row for empty text: bit zero plus one bit per leading star
  function automatic logic [MAX_PATTERN:0] star_prefix_row();
    logic [MAX_PATTERN:0] row;
    logic                 in_run;
    int                   j;
    row    = '0;
    row[0] = 1'b1;
    in_run = 1'b1;
    for (j = 0; j < MAX_PATTERN; j++) begin
      if (j < pattern_len) begin
        in_run     = in_run && (pattern_bytes[j] == STAR_CHAR);
        row[j + 1] = in_run;
      end
    end
    return row;
  endfunction

  // Advance the row by one text byte; an equal pattern byte wins over the star rule
  function automatic logic [MAX_PATTERN:0] advance_row(logic [MAX_PATTERN:0] prev, char_t ch);
    logic [MAX_PATTERN:0] row;
    char_t                q;
    int                   j;
    row = '0;
    for (j = 1; j <= MAX_PATTERN; j++) begin
      if (j <= pattern_len) begin
        q = pattern_bytes[j - 1];
        if (q == ch || q == QMARK_CHAR) begin
          row[j] = prev[j - 1];
        end else if (q == STAR_CHAR) begin
          row[j] = prev[j - 1] | prev[j] | row[j - 1];
        end
      end
    end
    return row;
  endfunction

  // Update the predicted state for one item transfer and queue its result
  task automatic predict_item(opcode_t op, char_t ch);
    match_result_t res;
    case (op)
      OP_CLEAR: begin
        pattern_len = 0;
        match_bits  = star_prefix_row();
      end
      OP_APPEND: begin
        if (pattern_len >= MAX_PATTERN) begin
          overflow_sticky = 1'b1;
        end else begin
          pattern_bytes[pattern_len] = ch;
          pattern_len++;
        end
        match_bits = star_prefix_row();
      end
      OP_START: begin
        match_bits   = star_prefix_row();
        res.matched  = match_bits[pattern_len];
        res.overflow = overflow_sticky;
        expected_q.push_back(res);
      end
      default: begin
        match_bits   = advance_row(match_bits, ch);
        res.matched  = match_bits[pattern_len];
        res.overflow = overflow_sticky;
        expected_q.push_back(res);
      end
    endcase
  endtask

  // Compare result transfers first: they belong to earlier items
  always @(posedge clk) begin : monitor
    match_result_t want;
    if (rst) begin
      pattern_len     = 0;
      match_bits      = '0;
      match_bits[0]   = 1'b1;
      overflow_sticky = 1'b0;
      expected_q.delete();
      mismatch_count  = 0;
      results_checked = 0;
      matches_seen    = 0;
      overflow_seen   = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected, matched", int'(matched), -1);
        end else begin
          want = expected_q.pop_front();
          if (matched !== want.matched) begin
            report_mismatch("matched", int'(matched), int'(want.matched));
          end
          if (overflow !== want.overflow) begin
            report_mismatch("overflow", int'(overflow), int'(want.overflow));
          end
          results_checked++;
          if (want.matched) matches_seen++;
          if (want.overflow) overflow_seen = 1'b1;
        end
      end
      if (item_valid && !item_stall) begin
        predict_item(opcode_t'(opcode), char_value);
      end
    end
    pending_count <= expected_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Wildcard pattern matcher testbench
// Drives directed and random command streams (pattern loads, text starts and
// text bytes built to match or nearly match the pattern) with random idle
// bursts and result stalls; the checker beside the block predicts and
// compares every result, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import wpm_pkg::*;

  localparam int MAX_PAT     = 32;
  localparam int ITEM_TARGET = 1300;
  localparam int CYCLE_LIMIT = 300000;

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  item_valid   = 1'b0;
  logic  item_stall;
  logic  [1:0] opcode = OP_CLEAR;
  char_t char_value   = 8'h00;
  logic  result_valid;
  logic  result_stall = 1'b0;
  logic  matched;
  logic  overflow;

  int   mismatch_count;
  int   pending_count;
  int   results_checked;
  int   matches_seen;
  logic overflow_seen;

  int items_sent  = 0;
  int burst_left  = 0;
  int cycle_count = 0;
  int hold_count  = 0;

  wildcard_pattern_matcher_top #(
    .MAX_PATTERN(MAX_PAT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .opcode      (opcode),
    .char_value  (char_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .matched     (matched),
    .overflow    (overflow)
  );

  wildcard_match_checker #(
    .MAX_PATTERN(MAX_PAT)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .opcode         (opcode),
    .char_value     (char_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .matched        (matched),
    .overflow       (overflow),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .results_checked(results_checked),
    .matches_seen   (matches_seen),
    .overflow_seen  (overflow_seen)
  );

  always #6 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall results on a changing pattern, with a long hold-off now and then
  always @(negedge clk) begin : result_sink
    int rx_cycle;
    int rx_mode;
    int mode_left;
    int hold_left;
    if (rst) begin
      result_stall <= 1'b0;
      rx_cycle  = 0;
      rx_mode   = 0;
      mode_left = 0;
      hold_left = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 1500 == 400) begin
        hold_left = 90;
        hold_count++;
      end
      if (mode_left == 0) begin
        rx_mode   = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        case (rx_mode)
          0:       result_stall <= 1'b0;
          1:       result_stall <= ($urandom_range(0, 3) == 0);
          2:       result_stall <= rx_cycle[0];
          default: result_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  function automatic char_t random_byte();
    return char_t'($urandom_range(0, 255));
  endfunction

  // Pattern bytes: mostly wildcards and a small alphabet
  function automatic char_t pattern_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return STAR_CHAR;
    if (r < 5) return QMARK_CHAR;
    if (r < 9) return char_t'(8'h61 + $urandom_range(0, 2));
    return random_byte();
  endfunction

  // Text bytes: same alphabet, wildcard bytes taken literally, some noise
  function automatic char_t text_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return char_t'(8'h61 + $urandom_range(0, 2));
    if (r == 7) return STAR_CHAR;
    if (r == 8) return QMARK_CHAR;
    return random_byte();
  endfunction

  // Offer one item in bursts with random gaps; return at the next falling edge
  task automatic send_item(opcode_t op, char_t ch);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    opcode     <= op;
    char_value <= ch;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Pause the sender until every outstanding result has come back
  task automatic drain_results();
    if (pending_count != 0) begin
      item_valid <= 1'b0;
      while (pending_count != 0) @(negedge clk);
    end
  endtask

  // Load a pattern, then stream a text built from it with occasional damage
  task automatic run_sequence(int plen);
    char_t pat [$];
    char_t txt [$];
    char_t ch;
    int    i;
    int    k;
    send_item(OP_CLEAR, random_byte());
    for (i = 0; i < plen; i++) begin
      ch = pattern_char();
      pat.push_back(ch);
      send_item(OP_APPEND, ch);
    end
    if ($urandom_range(0, 6) == 0) begin
      k = $urandom_range(0, 10);
      repeat (k) txt.push_back(text_char());
    end else begin
      for (i = 0; i < pat.size(); i++) begin
        if (pat[i] == STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) txt.push_back(text_char());
        end else if (pat[i] == QMARK_CHAR) begin
          txt.push_back(random_byte());
        end else begin
          txt.push_back(pat[i]);
        end
      end
      if (txt.size() != 0 && $urandom_range(0, 3) == 0) begin
        txt[$urandom_range(0, txt.size() - 1)] = text_char();
      end
      if ($urandom_range(0, 4) == 0) txt.push_back(text_char());
    end
    send_item(OP_START, random_byte());
    for (i = 0; i < txt.size(); i++) send_item(OP_TEXT, txt[i]);
    // restart the text now and then against the same pattern
    if ($urandom_range(0, 3) == 0) begin
      send_item(OP_START, random_byte());
      k = $urandom_range(0, 6);
      repeat (k) send_item(OP_TEXT, text_char());
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 6);
    if (r < 19) return $urandom_range(7, 16);
    return MAX_PAT;
  endfunction

  initial begin : stimulus
    int  n;
    bit  overflow_done;
    overflow_done = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty pattern against empty and one-byte text
    send_item(OP_START, 8'h00);
    send_item(OP_TEXT, 8'hFF);
    // leading stars match empty text; a literal star takes the single step
    send_item(OP_APPEND, STAR_CHAR);
    send_item(OP_APPEND, STAR_CHAR);
    send_item(OP_START, 8'h55);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, STAR_CHAR);
    send_item(OP_TEXT, QMARK_CHAR);
    // extreme bytes, question mark and a trailing star
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_APPEND, 8'h00);
    send_item(OP_APPEND, QMARK_CHAR);
    send_item(OP_APPEND, 8'hFF);
    send_item(OP_APPEND, STAR_CHAR);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'h80);
    send_item(OP_TEXT, 8'hFF);
    send_item(OP_TEXT, STAR_CHAR);
    send_item(OP_START, 8'hAA);
    send_item(OP_TEXT, QMARK_CHAR);
    // an append mid-text restarts the text as empty
    send_item(OP_APPEND, 8'h61);
    send_item(OP_TEXT, 8'h00);
    send_item(OP_TEXT, 8'h7F);
    drain_results();

    // random sequences, with one overflowing pattern around the middle
    while (items_sent < ITEM_TARGET) begin
      if (!overflow_done && items_sent >= ITEM_TARGET / 2) begin
        drain_results();
        run_sequence(MAX_PAT + 3);
        overflow_done = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(opcode_t'($urandom_range(0, 3)), random_byte());
      end else begin
        run_sequence(pick_length());
      end
    end

    item_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items; checked %0d results, %0d of them matches.",
             items_sent, results_checked, matches_seen);
    $display("Long result hold-offs: %0d; sticky overflow observed: %0d.",
             hold_count, overflow_seen);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
